@@ design/dgvb_pkg.sv @@
package dgvb_pkg;

    // default geometry
    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 480;
    localparam int CELL_SIZE    = 16;
    localparam int CELLS_ACROSS = 40;
    localparam int CELLS_DOWN   = 30;

    // field widths
    localparam int KIND_W  = 2;
    localparam int ROW_W   = 9;
    localparam int COL_W   = 10;
    localparam int DISP_W  = 8;
    localparam int PDISP_W = 7;
    localparam int CIDX_W  = 11;
    localparam int HALF_W  = 64;
    localparam int MASK_W  = 2 * HALF_W;
    localparam int GAP_W   = 8;

    // reciprocal divide: exact while col * CELL_SIZE < 2**DIV_SHIFT
    localparam int DIV_SHIFT = 16;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = COL_W + RECIP_W;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    // result kinds
    localparam logic RES_POINT = 1'b0;
    localparam logic RES_MASK  = 1'b1;

    typedef logic [MASK_W-1:0] mask_t;

    // three-bit band d-1..d+1, clipped at both ends of the mask
    function automatic mask_t band_mask(input logic [PDISP_W-1:0] d);
        logic [MASK_W+1:0] wide;
        wide = (MASK_W + 2)'(3'b111) << d;
        return wide[MASK_W:1];
    endfunction

endpackage

@@ design/dgvb_if.sv @@
interface dgvb_item_if;
    logic                              valid;
    logic                              ready;
    logic [dgvb_pkg::KIND_W-1:0]       kind;
    logic [dgvb_pkg::ROW_W-1:0]        pixel_row;
    logic [dgvb_pkg::COL_W-1:0]        pixel_col;
    logic signed [dgvb_pkg::DISP_W-1:0] disparity;
    logic [dgvb_pkg::CIDX_W-1:0]       cell_index;

    modport source (output valid, kind, pixel_row, pixel_col, disparity, cell_index,
                    input ready);
    modport sink (input valid, kind, pixel_row, pixel_col, disparity, cell_index,
                  output ready);
endinterface

interface dgvb_result_if;
    logic                         valid;
    logic                         ready;
    logic                         result_kind;
    logic [dgvb_pkg::ROW_W-1:0]   point_row;
    logic [dgvb_pkg::COL_W-1:0]   point_col;
    logic [dgvb_pkg::PDISP_W-1:0] point_disparity;
    logic [dgvb_pkg::HALF_W-1:0]  mask_low;
    logic [dgvb_pkg::HALF_W-1:0]  mask_high;

    modport source (output valid, result_kind, point_row, point_col, point_disparity,
                    mask_low, mask_high, input ready);
    modport sink (input valid, result_kind, point_row, point_col, point_disparity,
                  mask_low, mask_high, output ready);
endinterface

interface dgvb_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [dgvb_pkg::GAP_W-1:0]  downsample_gap;

    modport source (output valid, downsample_gap, input ready);
    modport sink (input valid, downsample_gap, output ready);
endinterface

@@ design/dgvb_mask_ram.sv @@
module dgvb_mask_ram #(
    parameter int DEPTH = dgvb_pkg::CELLS_ACROSS * dgvb_pkg::CELLS_DOWN,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = dgvb_pkg::MASK_W
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mask_mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mask_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mask_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/dgvb_cell_map.sv @@
module dgvb_cell_map #(
    parameter int IMAGE_WIDTH  = dgvb_pkg::IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = dgvb_pkg::IMAGE_HEIGHT,
    parameter int CELL_SIZE    = dgvb_pkg::CELL_SIZE,
    parameter int CELLS_ACROSS = dgvb_pkg::CELLS_ACROSS,
    parameter int CELLS_DOWN   = dgvb_pkg::CELLS_DOWN,
    parameter int AW           = 11
) (
    input  logic                         clk,
    input  logic                         prod_en,
    input  logic [dgvb_pkg::ROW_W-1:0]   row,
    input  logic [dgvb_pkg::COL_W-1:0]   col,
    input  logic                         addr_en,
    output logic [AW-1:0]                cell_addr,
    output logic                         in_grid
);

    localparam int RECIP = (2 ** dgvb_pkg::DIV_SHIFT + CELL_SIZE - 1) / CELL_SIZE;

    // stage 1: reciprocal products and image bounds
    logic [dgvb_pkg::PROD_W-1:0] row_prod_reg;
    logic [dgvb_pkg::PROD_W-1:0] col_prod_reg;
    logic                        row_ok_reg;
    logic                        col_ok_reg;

    // stage 2: row-major cell address
    logic [dgvb_pkg::ROW_W-1:0]  cy;
    logic [dgvb_pkg::COL_W-1:0]  cx;
    logic [AW-1:0]               cell_addr_reg;
    logic                        in_grid_reg;
    logic [31:0]                 addr_full;

    always_ff @(posedge clk)
    begin
        if (prod_en)
        begin
            row_prod_reg <= dgvb_pkg::PROD_W'(row) * dgvb_pkg::PROD_W'(RECIP);
            col_prod_reg <= dgvb_pkg::PROD_W'(col) * dgvb_pkg::PROD_W'(RECIP);
            row_ok_reg   <= 32'(row) < 32'(IMAGE_HEIGHT);
            col_ok_reg   <= 32'(col) < 32'(IMAGE_WIDTH);
        end
    end

    assign cy        = row_prod_reg[dgvb_pkg::DIV_SHIFT +: dgvb_pkg::ROW_W];
    assign cx        = col_prod_reg[dgvb_pkg::DIV_SHIFT +: dgvb_pkg::COL_W];
    assign addr_full = 32'(cy) * 32'(CELLS_ACROSS) + 32'(cx);

    always_ff @(posedge clk)
    begin
        if (addr_en)
        begin
            cell_addr_reg <= addr_full[AW-1:0];
            in_grid_reg   <= row_ok_reg && col_ok_reg
                             && (32'(cx) < 32'(CELLS_ACROSS))
                             && (32'(cy) < 32'(CELLS_DOWN));
        end
    end

    assign cell_addr = cell_addr_reg;
    assign in_grid   = in_grid_reg;

endmodule

@@ design/disparity_grid_vector_builder.sv @@
// Support-point disparity grid. Each pixel transaction with a non-negative
// disparity inside the image ORs a three-bit band (d-1, d, d+1, clipped to
// 0..127) into the 128-bit mask of its grid cell and returns as a result every
// (downsample_gap+1)th such point, from the first on after a clear transaction.
// A read transaction returns one cell's mask (zero beyond the grid). Pixel and
// read transactions go through accept with the reciprocal-multiply cell divide,
// cell address, mask memory read, then update and write back, which a pending
// result can stall; the next item is accepted only after this read-modify-write
// pass through the mask memory. After reset and every clear transaction the
// block clears all CELLS_ACROSS*CELLS_DOWN cells (1200 by default) and accepts
// no item meanwhile; configuration writes are taken at any time. Results wait
// in an output register, so the next item is taken while a result is pending.
module disparity_grid_vector_builder #(
    parameter int IMAGE_WIDTH  = dgvb_pkg::IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = dgvb_pkg::IMAGE_HEIGHT,
    parameter int CELL_SIZE    = dgvb_pkg::CELL_SIZE,
    parameter int CELLS_ACROSS = dgvb_pkg::CELLS_ACROSS,
    parameter int CELLS_DOWN   = dgvb_pkg::CELLS_DOWN
) (
    input  logic           clk,
    input  logic           rst_n,
    dgvb_item_if.sink      items,
    dgvb_result_if.source  results,
    dgvb_cfg_if.sink       cfg
);

    localparam int CELL_COUNT = CELLS_ACROSS * CELLS_DOWN;
    localparam int AW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MAP   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;

    logic [2:0]                      state_reg, state_next;
    logic [AW-1:0]                   clr_addr_reg, clr_addr_next;
    logic [dgvb_pkg::GAP_W-1:0]      gap_reg, gap_next;
    logic [dgvb_pkg::GAP_W-1:0]      skip_cnt_reg, skip_cnt_next;

    logic [dgvb_pkg::KIND_W-1:0]     kind_reg;
    logic [dgvb_pkg::ROW_W-1:0]      row_reg;
    logic [dgvb_pkg::COL_W-1:0]      col_reg;
    logic signed [dgvb_pkg::DISP_W-1:0] disp_reg;
    logic [dgvb_pkg::CIDX_W-1:0]     cidx_reg;
    logic                            cidx_ok_reg;

    logic                            out_valid_reg, out_valid_next;
    logic                            out_kind_reg;
    logic [dgvb_pkg::ROW_W-1:0]      out_row_reg;
    logic [dgvb_pkg::COL_W-1:0]      out_col_reg;
    logic [dgvb_pkg::PDISP_W-1:0]    out_disp_reg;
    logic [dgvb_pkg::HALF_W-1:0]     out_low_reg;
    logic [dgvb_pkg::HALF_W-1:0]     out_high_reg;

    logic                            item_acc;
    logic                            clear_acc;
    logic [AW-1:0]                   cell_addr;
    logic                            in_grid;

    logic                            mem_wr_en;
    logic [AW-1:0]                   mem_wr_addr;
    dgvb_pkg::mask_t                 mem_wr_data;
    logic                            mem_rd_en;
    logic [AW-1:0]                   mem_rd_addr;
    dgvb_pkg::mask_t                 mem_rd_data;
    dgvb_pkg::mask_t                 read_mask;

    logic                            is_pixel;
    logic                            hit_pix;
    logic                            emit_pt;
    logic                            need_out;
    logic                            slot_free;
    logic                            advance;
    logic                            out_load;

    assign item_acc  = items.valid && items.ready;
    assign clear_acc = item_acc && (items.kind == dgvb_pkg::KIND_CLEAR);
    assign items.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;

    dgvb_cell_map #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .CELL_SIZE    (CELL_SIZE),
        .CELLS_ACROSS (CELLS_ACROSS),
        .CELLS_DOWN   (CELLS_DOWN),
        .AW           (AW)
    ) u_cell_map (
        .clk       (clk),
        .prod_en   (item_acc),
        .row       (items.pixel_row),
        .col       (items.pixel_col),
        .addr_en   (state_reg == S_MAP),
        .cell_addr (cell_addr),
        .in_grid   (in_grid)
    );

    dgvb_mask_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (AW),
        .DW    (dgvb_pkg::MASK_W)
    ) u_mask_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // decisions in the update cycle
    assign is_pixel  = (kind_reg == dgvb_pkg::KIND_PIXEL);
    assign hit_pix   = is_pixel && !disp_reg[dgvb_pkg::DISP_W-1] && in_grid;
    assign emit_pt   = hit_pix && (skip_cnt_reg == gap_reg);
    assign need_out  = emit_pt || !is_pixel;
    assign slot_free = !out_valid_reg || results.ready;
    assign advance   = !need_out || slot_free;
    assign out_load  = (state_reg == S_MOD) && need_out && slot_free;

    assign read_mask = cidx_ok_reg ? mem_rd_data : '0;

    assign mem_rd_en   = (state_reg == S_READ);
    assign mem_rd_addr = (kind_reg == dgvb_pkg::KIND_READ) ? AW'(cidx_reg) : cell_addr;

    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = clr_addr_reg;
        mem_wr_data = '0;
        if (state_reg == S_CLEAR)
        begin
            mem_wr_en = 1'b1;
        end
        else if ((state_reg == S_MOD) && advance && hit_pix)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cell_addr;
            mem_wr_data = mem_rd_data
                          | dgvb_pkg::band_mask(disp_reg[dgvb_pkg::PDISP_W-1:0]);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        skip_cnt_next = skip_cnt_reg;
        gap_next      = cfg.valid ? cfg.downsample_gap : gap_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(CELL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_acc)
                begin
                    case (items.kind) inside
                        dgvb_pkg::KIND_PIXEL, dgvb_pkg::KIND_READ:
                        begin
                            state_next = S_MAP;
                        end
                        dgvb_pkg::KIND_CLEAR:
                        begin
                            state_next    = S_CLEAR;
                            clr_addr_next = '0;
                            skip_cnt_next = gap_reg;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MAP:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (advance)
                begin
                    state_next = S_IDLE;
                    if (hit_pix)
                    begin
                        skip_cnt_next = emit_pt ? '0 : skip_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            gap_reg       <= '0;
            skip_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            gap_reg       <= gap_next;
            skip_cnt_reg  <= skip_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            kind_reg    <= items.kind;
            row_reg     <= items.pixel_row;
            col_reg     <= items.pixel_col;
            disp_reg    <= items.disparity;
            cidx_reg    <= items.cell_index;
            cidx_ok_reg <= 32'(items.cell_index) < 32'(CELL_COUNT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (is_pixel)
            begin
                out_kind_reg <= dgvb_pkg::RES_POINT;
                out_row_reg  <= row_reg;
                out_col_reg  <= col_reg;
                out_disp_reg <= disp_reg[dgvb_pkg::PDISP_W-1:0];
                out_low_reg  <= '0;
                out_high_reg <= '0;
            end
            else
            begin
                out_kind_reg <= dgvb_pkg::RES_MASK;
                out_row_reg  <= '0;
                out_col_reg  <= '0;
                out_disp_reg <= '0;
                out_low_reg  <= read_mask[dgvb_pkg::HALF_W-1:0];
                out_high_reg <= read_mask[dgvb_pkg::MASK_W-1:dgvb_pkg::HALF_W];
            end
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.result_kind     = out_kind_reg;
    assign results.point_row       = out_row_reg;
    assign results.point_col       = out_col_reg;
    assign results.point_disparity = out_disp_reg;
    assign results.mask_low        = out_low_reg;
    assign results.mask_high       = out_high_reg;

    // single-port discipline: reads and writes of the mask memory never overlap
    a_mem_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("mask memory read and write in the same cycle");

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (32'(mem_wr_addr) < 32'(CELL_COUNT)))
        else $error("mask memory write beyond the grid");

    a_emit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && emit_pt) |=> (skip_cnt_reg == '0))
        else $error("skip counter not restarted after an emitted point");

    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != S_MOD) && !clear_acc) |=> $stable(skip_cnt_reg))
        else $error("skip counter moved outside an update or clear");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || results.ready))
        else $error("pending result overwritten");

endmodule
